@@ rtl/core/psf_pkg.sv @@
// psf_pkg: shared types and constants for the planar span fill block.
// Used by psf_ctrl, psf_dpath and planar_span_fill; depends on nothing.
`default_nettype none

package psf_pkg;

	localparam int PLANES_DEF = 4;

	localparam int ROW_W   = 9;
	localparam int X_W     = 10;
	localparam int SPAN_W  = 11;
	localparam int COLOR_W = 4;
	localparam int ADDR_W  = 24;
	localparam int MASK_W  = 16;
	localparam int GRP_W   = 6;
	localparam int BIT_W   = 4;

	localparam int BASE_W   = 23;
	localparam int STRIDE_W = 10;
	localparam int SCR_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd2;

	localparam logic [BASE_W-1:0]   BASE_RST   = 23'd0;
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 10'd80;
	localparam logic [SCR_W-1:0]    SCR_RST    = 11'd320;
	localparam logic [SCR_W-1:0]    MAX_CLIP   = 11'd1024;

	localparam logic [MASK_W-1:0] MASK_ALL   = 16'hFFFF;
	localparam logic [MASK_W-1:0] MASK_RIGHT = 16'h7FFF;

	typedef struct packed {
		logic load;
		logic prep;
		logic emit;
	} psf_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_grp;
		logic out_free;
	} psf_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/psf_ctrl.sv @@
// psf_ctrl: sequencer for the planar span fill block.
// Issues load, prep and emit commands to psf_dpath; uses psf_pkg.
`default_nettype none

module psf_ctrl
	import psf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  psf_sts_t      sts,
	output psf_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		cmd.load = s_tvalid && ready_q;
		cmd.prep = (state_q == ST_PREP);
		cmd.emit = (state_q == ST_RUN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ready_q <= 1'b1;
					if (s_tvalid && ready_q) begin
						state_q <= ST_PREP;
						ready_q <= 1'b0;
					end
				end
				ST_PREP: begin
					if (sts.empty) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (sts.out_free && sts.last_grp) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/psf_dpath.sv @@
// psf_dpath: registers, clipping, address and mask logic and output beat register.
// Driven by psf_ctrl commands; uses psf_pkg.
`default_nettype none

module psf_dpath
	import psf_pkg::*;
#(
	parameter int PLANES = PLANES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser,
	input  psf_cmd_t                   cmd,
	output psf_sts_t                   sts
);

	localparam logic [COLOR_W-1:0] PLANE_MASK =
		(PLANES >= COLOR_W) ? {COLOR_W{1'b1}} : COLOR_W'((1 << PLANES) - 1);
	localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(PLANES);

	logic [BASE_W-1:0]   base_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [SCR_W-1:0]    scr_q;

	logic [X_W-1:0]          x_q;
	logic [SPAN_W-1:0]       w_q;
	logic [COLOR_W-1:0]      bits_q;
	logic                    last_row_q;
	logic [ROW_W+STRIDE_W-1:0] prod_q;

	logic [ADDR_W-1:0] addr_q;
	logic [GRP_W-1:0]  grp_q;
	logic [GRP_W-1:0]  grp_r_q;
	logic [BIT_W-1:0]  bit_r_q;

	logic [ADDR_W-1:0] out_addr_q;
	logic [MASK_W-1:0] out_mask_q;
	logic [COLOR_W-1:0] out_bits_q;
	logic              out_last_q;
	logic              out_eor_q;
	logic              out_valid_q;

	logic [SCR_W-1:0]  clip;
	logic [SCR_W:0]    sum;
	logic [SCR_W-1:0]  span_end;
	logic [SCR_W-1:0]  x_last;
	logic              empty;
	logic              last_grp;
	logic [MASK_W-1:0] mask;

	always_comb begin
		clip     = (scr_q > MAX_CLIP) ? MAX_CLIP : scr_q;
		empty    = (w_q == '0) || ({1'b0, x_q} >= clip);
		sum      = {2'b00, x_q} + {1'b0, w_q};
		span_end = (sum > {1'b0, clip}) ? clip : sum[SCR_W-1:0];
		x_last   = span_end - SCR_W'(1);
		last_grp = (grp_q == grp_r_q);
		mask     = MASK_ALL;
		if (grp_q == x_q[X_W-1:BIT_W])
			mask = mask & (MASK_ALL >> x_q[BIT_W-1:0]);
		if (last_grp)
			mask = mask & ~(MASK_RIGHT >> bit_r_q);
	end

	assign sts.empty    = empty;
	assign sts.last_grp = last_grp;
	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_bits_q, out_mask_q, out_addr_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_eor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RST;
			stride_q <= STRIDE_RST;
			scr_q    <= SCR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_BASE:   base_q   <= cfg_wdata[BASE_W-1:0];
				CFG_LINE_STRIDE:  stride_q <= cfg_wdata[STRIDE_W-1:0];
				CFG_SCREEN_WIDTH: scr_q    <= cfg_wdata[SCR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q        <= s_tdata[ROW_W +: X_W];
			w_q        <= s_tdata[ROW_W+X_W +: SPAN_W];
			bits_q     <= s_tdata[ROW_W+X_W+SPAN_W +: COLOR_W] & PLANE_MASK;
			last_row_q <= s_tlast;
			prod_q     <= s_tdata[ROW_W-1:0] * stride_q;
		end
		if (cmd.prep) begin
			addr_q  <= {1'b0, base_q} + ADDR_W'(prod_q)
				+ ADDR_W'(x_q[X_W-1:BIT_W]) * ADDR_STEP;
			grp_q   <= x_q[X_W-1:BIT_W];
			grp_r_q <= x_last[X_W-1:BIT_W];
			bit_r_q <= x_last[BIT_W-1:0];
		end
		if (cmd.emit) begin
			out_addr_q <= addr_q;
			out_mask_q <= mask;
			out_bits_q <= bits_q;
			out_last_q <= last_grp;
			out_eor_q  <= last_grp && last_row_q;
			addr_q     <= addr_q + ADDR_STEP;
			grp_q      <= grp_q + GRP_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/planar_span_fill.sv @@
// planar_span_fill: top level of the interleaved-bitplane span fill block.
// Instantiates psf_ctrl and psf_dpath; uses psf_pkg.
//
// One input beat is one row of a rectangle; the block clips it to the screen width
// and emits one masked write beat per 16-pixel group, left to right. A row holds
// the input side through its steps: the accept step takes the beat and forms
// row * stride, the prep step adds the frame base and clips the span, then the
// run step issues one group per cycle from the single output register, slowed
// only by m_tready. An empty row skips the run step. The next row is accepted
// while the final beat of the previous row still waits.
`default_nettype none

module planar_span_fill
	import psf_pkg::*;
#(
	parameter int PLANES = PLANES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// row_index[8:0], x_start[18:9], span_width[29:19], fill_color[33:30], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// last_row
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// word_address[23:0], pixel_mask[39:24], plane_bits[43:40], zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// last_of_span
	output logic                       m_tlast,
	// end_of_rect
	output logic                       m_tuser
);

	psf_cmd_t cmd;
	psf_sts_t sts;

	psf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psf_dpath #(
		.PLANES (PLANES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_planar_span_fill.sv @@
// tb_planar_span_fill: self-checking testbench for the planar span fill block.
// Walks a directed table, then random rows under several register settings,
// and checks every mask write beat against a predictor or table entry; depends on psf_pkg.
`timescale 1ns / 100ps

module tb_planar_span_fill
	import psf_pkg::*;
;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SEGMENTS     = 9;
	localparam int SEG_ROWS     = 35;
	localparam int DIR_LEN      = 25;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [X_W-1:0]     x;
		logic [SPAN_W-1:0]  width;
		logic [COLOR_W-1:0] color;
		logic               last_row;
	} fill_row_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [MASK_W-1:0]  mask;
		logic [COLOR_W-1:0] planes;
		logic               last_of_span;
		logic               end_of_rect;
	} mask_write_t;

	typedef enum logic [1:0] {STEP_ROW, STEP_REG} step_kind_e;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

	typedef struct packed {
		step_kind_e              kind;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
		fill_row_t               beat;
		row_check_e              chk;
		mask_write_t             want;
	} dir_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	logic [BASE_W-1:0]   base_word = BASE_RST;
	logic [STRIDE_W-1:0] stride_words = STRIDE_RST;
	logic [SCR_W-1:0]    screen_px = SCR_RST;

	mask_write_t pending_writes[$];
	dir_step_t   dir_table [0:DIR_LEN-1];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          src_idle_pct = 32;
	int          sink_idle_pct = 56;
	int          stall_left = 0;

	planar_span_fill dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic dir_step_t row_step(fill_row_t r, row_check_e chk, mask_write_t w);
		dir_step_t s;
		s = '0;
		s.kind = STEP_ROW;
		s.beat = r;
		s.chk = chk;
		s.want = w;
		return s;
	endfunction

	function automatic dir_step_t reg_step(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		dir_step_t s;
		s = '0;
		s.kind = STEP_REG;
		s.reg_idx = idx;
		s.reg_val = val;
		s.chk = CHK_NONE;
		return s;
	endfunction

	function automatic int unsigned clip_px();
		return (screen_px > MAX_CLIP) ? int'(MAX_CLIP) : int'(screen_px);
	endfunction

	function automatic void predict_row_writes(fill_row_t r);
		int unsigned clip, span_end, x_last, grp_l, grp_r, line_addr, keep;
		logic [3:0]  bit_l, bit_r;
		mask_write_t w;
		clip = clip_px();
		if (r.width == 0 || int'(r.x) >= clip)
			return;
		span_end = r.x + r.width;
		if (span_end > clip)
			span_end = clip;
		x_last = span_end - 1;
		grp_l = r.x >> 4;
		grp_r = x_last >> 4;
		bit_l = r.x[3:0];
		bit_r = x_last[3:0];
		keep = (1 << PLANES_DEF) - 1;
		line_addr = base_word + r.row * stride_words;
		for (int unsigned g = grp_l; g <= grp_r; g++) begin
			w.mask = 16'hFFFF;
			if (g == grp_l)
				w.mask = w.mask & (16'hFFFF >> bit_l);
			if (g == grp_r)
				w.mask = w.mask & ~(16'h7FFF >> bit_r);
			w.addr = ADDR_W'(line_addr + g * PLANES_DEF);
			w.planes = r.color & keep[COLOR_W-1:0];
			w.last_of_span = (g == grp_r);
			w.end_of_rect = (g == grp_r) && r.last_row;
			pending_writes.push_back(w);
		end
	endfunction

	task automatic send_row(fill_row_t r, row_check_e chk, mask_write_t w);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - 34){1'b0}}, r.color, r.width, r.x, r.row};
		s_tlast <= r.last_row;
		do @(posedge clk); while (!s_tready);
		case (chk)
			CHK_MODEL: predict_row_writes(r);
			CHK_ONE:   pending_writes.push_back(w);
			default:   ;
		endcase
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_BASE:   base_word = val[BASE_W-1:0];
			CFG_LINE_STRIDE:  stride_words = val[STRIDE_W-1:0];
			CFG_SCREEN_WIDTH: screen_px = val[SCR_W-1:0];
			default:          ;
		endcase
	endtask

	// receiver: random backpressure plus a long hold-off in one segment
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_writes
		mask_write_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.addr = m_tdata[ADDR_W-1:0];
			got.mask = m_tdata[ADDR_W+MASK_W-1:ADDR_W];
			got.planes = m_tdata[ADDR_W+MASK_W+COLOR_W-1:ADDR_W+MASK_W];
			got.last_of_span = m_tlast;
			got.end_of_rect = m_tuser;
			if (pending_writes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected beat: addr %h mask %h planes %h last %b eor %b",
						got.addr, got.mask, got.planes, got.last_of_span, got.end_of_rect);
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("mismatch: exp addr %h mask %h planes %h last %b eor %b,",
							want.addr, want.mask, want.planes, want.last_of_span,
							want.end_of_rect);
						$display(" got addr %h mask %h planes %h last %b eor %b",
							got.addr, got.mask, got.planes,
							got.last_of_span, got.end_of_rect);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[planar_span_fill] ERROR");
		$finish;
	end

	initial begin
		fill_row_t             r;
		int unsigned           clip, mode, hi;
		logic [CFG_DATA_W-1:0] base_v, stride_v, width_v;

		dir_table = '{
			row_step('{9'd0, 10'd0, 11'd16, 4'hF, 1'b1}, CHK_ONE,
				'{24'd0, 16'hFFFF, 4'hF, 1'b1, 1'b1}),
			row_step('{9'd0, 10'd0, 11'd0, 4'hF, 1'b1}, CHK_NONE, '0),
			row_step('{9'd511, 10'd1023, 11'd1024, 4'h0, 1'b0}, CHK_NONE, '0),
			row_step('{9'd1, 10'd3, 11'd1, 4'h5, 1'b0}, CHK_ONE,
				'{24'd80, 16'h1000, 4'h5, 1'b1, 1'b0}),
			row_step('{9'd2, 10'd0, 11'd320, 4'hA, 1'b1}, CHK_MODEL, '0),
			row_step('{9'd511, 10'd319, 11'd1, 4'hF, 1'b1}, CHK_ONE,
				'{24'd40956, 16'h0001, 4'hF, 1'b1, 1'b1}),
			row_step('{9'd3, 10'd5, 11'd1024, 4'h3, 1'b0}, CHK_MODEL, '0),
			row_step('{9'd4, 10'd15, 11'd2, 4'h9, 1'b1}, CHK_MODEL, '0),
			row_step('{9'd0, 10'd320, 11'd5, 4'h6, 1'b1}, CHK_NONE, '0),
			row_step('{9'd5, 10'd0, 11'd2047, 4'hC, 1'b0}, CHK_MODEL, '0),
			row_step('{9'd6, 10'd17, 11'd30, 4'hC, 1'b1}, CHK_MODEL, '0),
			row_step('{9'd7, 10'd0, 11'd1, 4'h1, 1'b0}, CHK_ONE,
				'{24'd560, 16'h8000, 4'h1, 1'b1, 1'b0}),
			reg_step(CFG_FRAME_BASE, 23'h7FFFFF),
			reg_step(CFG_LINE_STRIDE, 23'd1023),
			reg_step(CFG_SCREEN_WIDTH, 23'd2047),
			row_step('{9'd511, 10'd0, 11'd1024, 4'hF, 1'b1}, CHK_MODEL, '0),
			row_step('{9'd511, 10'd1023, 11'd1, 4'hF, 1'b1}, CHK_MODEL, '0),
			row_step('{9'd100, 10'd1000, 11'd2047, 4'h7, 1'b0}, CHK_MODEL, '0),
			reg_step(CFG_LINE_STRIDE, 23'd0),
			row_step('{9'd300, 10'd8, 11'd16, 4'hB, 1'b1}, CHK_MODEL, '0),
			reg_step(CFG_SCREEN_WIDTH, 23'd0),
			row_step('{9'd0, 10'd0, 11'd1, 4'hF, 1'b1}, CHK_NONE, '0),
			reg_step(CFG_SCREEN_WIDTH, 23'd15),
			row_step('{9'd9, 10'd0, 11'd1024, 4'h2, 1'b1}, CHK_MODEL, '0),
			reg_step(CFG_SCREEN_WIDTH, 23'd1024)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_LEN; i++) begin
			if (dir_table[i].kind == STEP_REG)
				write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
			else
				send_row(dir_table[i].beat, dir_table[i].chk, dir_table[i].want);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 3) begin
				src_idle_pct = 32;
				sink_idle_pct = 56;
			end else if (seg < 6) begin
				src_idle_pct = 56;
				sink_idle_pct = 32;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			hi = (seg >= 6) ? $urandom : 0;
			base_v = CFG_DATA_W'($urandom_range(0, 23'h7FFFFF));
			stride_v = CFG_DATA_W'($urandom_range(1, 1023));
			mode = $urandom_range(0, 3);
			if (mode == 0)
				width_v = CFG_DATA_W'($urandom_range(0, 15));
			else if (mode == 1)
				width_v = CFG_DATA_W'($urandom_range(1025, 2047));
			else
				width_v = CFG_DATA_W'($urandom_range(16, 1024));
			case (seg)
				0: begin
					base_v = 23'h7FFFFF;
					stride_v = 23'd1023;
					width_v = 23'd2047;
				end
				1: begin
					base_v = 23'd0;
					stride_v = 23'd1;
					width_v = 23'd16;
				end
				2: begin
					stride_v = 23'd0;
					width_v = CFG_DATA_W'($urandom_range(0, 15));
				end
				3: width_v = 23'd1024;
				default: ;
			endcase
			write_reg(CFG_FRAME_BASE, base_v | CFG_DATA_W'(hi << BASE_W));
			write_reg(CFG_LINE_STRIDE, stride_v | CFG_DATA_W'(hi << STRIDE_W));
			write_reg(CFG_SCREEN_WIDTH, width_v | CFG_DATA_W'(hi << SCR_W));
			// hold the output long enough for the block to back up its input
			if (seg == 3)
				stall_left = 400;
			clip = clip_px();
			for (int n = 0; n < SEG_ROWS; n++) begin
				r.row = ROW_W'($urandom_range(0, 511));
				if (clip > 0 && $urandom_range(0, 9) < 8)
					r.x = X_W'($urandom_range(0, clip - 1));
				else
					r.x = X_W'($urandom_range(0, 1023));
				mode = $urandom_range(0, 9);
				if (mode == 0)
					r.width = '0;
				else if (mode == 1)
					r.width = SPAN_W'($urandom_range(0, 2047));
				else if (mode == 2)
					r.width = SPAN_W'($urandom_range(1024, 2047));
				else
					r.width = SPAN_W'($urandom_range(1, 48));
				r.color = COLOR_W'($urandom_range(0, 15));
				r.last_row = 1'($urandom_range(0, 1));
				send_row(r, CHK_MODEL, '0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (pending_writes.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("[planar_span_fill] OK");
		else
			$display("[planar_span_fill] ERROR");
		$finish;
	end

endmodule
